// File: sv/sdf_pkg.sv
// Shared constants, state codes and the binary-to-BCD step used by the
// signed decimal text formatter. No dependencies.
package sdf_pkg;

  // Field limits.
  localparam int MAX_WIDTH     = 64;
  localparam int MAX_PRECISION = 63;

  // Decimal conversion geometry: 20 digits cover any 64-bit magnitude.
  localparam int VAL_W     = 64;
  localparam int NUM_DIGITS = 20;
  localparam int BCD_W     = 4 * NUM_DIGITS;
  localparam int DAB_W     = BCD_W + VAL_W;
  localparam int CONV_STEPS = VAL_W / 2;

  // Style flag bit positions.
  localparam int FLAG_FORCE_PLUS = 0;
  localparam int FLAG_SPACE = 1;
  localparam int FLAG_LEFT  = 2;
  localparam int FLAG_ZERO  = 3;
  localparam int FLAG_PREC  = 4;

  // ASCII codes.
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_PLUS  = 8'h2B;
  localparam logic [7:0] CHR_MINUS = 8'h2D;
  localparam logic [7:0] CHR_ZERO  = 8'h30;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CONV   = 6'b000010,
    ST_TRIM   = 6'b000100,
    ST_SETUP  = 6'b001000,
    ST_LAYOUT = 6'b010000,
    ST_EMIT   = 6'b100000
  } sdf_state_t;

  // One double-dabble step: adjust every BCD digit that is five or more,
  // then shift the combined BCD and binary word left by one bit.
  function automatic logic [DAB_W-1:0] dabble_step(input logic [DAB_W-1:0] x);
    logic [DAB_W-1:0] y;
    y = x;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (y[VAL_W + 4*i +: 4] >= 4'd5) begin
        y[VAL_W + 4*i +: 4] = y[VAL_W + 4*i +: 4] + 4'd3;
      end
    end
    return {y[DAB_W-2:0], 1'b0};
  endfunction

endpackage

// File: sv/signed_decimal_text_formatter.sv
// Top level of the signed decimal text formatter: conversion sequencer and
// character emitter. Depends on sdf_pkg.
//
// Usage: a value is taken when start is high while busy is low. The block
// then stays busy for the whole item: binary-to-BCD conversion (one shared
// double-dabble unit, two bits per cycle), stripping of leading zero digits,
// laying out the padding in the setup and layout states, then the characters.
// Characters come out on consecutive cycles, each marked by out_valid for
// exactly one cycle, with out_last on the final one; the receiver cannot
// stall, so it must take every transfer. A value that formats to empty text
// (zero with precision zero, no sign, no width) produces no transfer but
// still passes through the emit state. The last character shows in the first
// cycle with busy low, so a new start may overlap it.
module signed_decimal_text_formatter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [sdf_pkg::VAL_W-1:0] in_value,
  input  logic [6:0]                  in_field_width,
  input  logic [5:0]                  in_min_digits,
  input  logic [4:0]                  in_style_flags,
  output logic                        out_valid,
  output logic [7:0]                  out_character,
  output logic                        out_last
);
  import sdf_pkg::*;

  sdf_state_t        state_r, state_nxt;
  logic [VAL_W-1:0]  mag_r, mag_nxt;
  logic [BCD_W-1:0]  bcd_r, bcd_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [4:0]        ndig_r, ndig_nxt;
  logic [6:0]        width_r, width_nxt;
  logic [5:0]        prec_r, prec_nxt;
  logic [4:0]        flags_r, flags_nxt;
  logic              neg_r, neg_nxt;
  logic [6:0]        pad_r, pad_nxt;
  logic [5:0]        zeros_r, zeros_nxt;
  logic              slen_r, slen_nxt;
  logic              zp_r, zp_nxt;
  logic [6:0]        b1_r, b1_nxt;
  logic [6:0]        b2_r, b2_nxt;
  logic [6:0]        b4_r, b4_nxt;
  logic [6:0]        b5_r, b5_nxt;
  logic [6:0]        total_r, total_nxt;
  logic [6:0]        pos_r, pos_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;

  logic              accept;
  logic              most_neg;
  logic [DAB_W-1:0]  dab_in, dab_out;
  logic [5:0]        min_dig, blen;
  logic [6:0]        len7;
  logic [6:0]        lead, b3;
  logic [7:0]        sign_chr;
  logic              in_digits;
  logic              emit_last;

  assign accept   = start && !busy;
  assign most_neg = (in_value == {1'b1, {(VAL_W-1){1'b0}}});
  assign busy     = (state_r != ST_IDLE);

  // Shared conversion unit: two double-dabble steps per cycle.
  assign dab_in  = {bcd_r, mag_r};
  assign dab_out = dabble_step(dabble_step(dab_in));

  // Length arithmetic for the setup and layout cycles.
  always_comb begin
    min_dig = flags_r[FLAG_PREC] ? prec_r : 6'd1;
    blen    = ({1'b0, ndig_r} > min_dig) ? {1'b0, ndig_r} : min_dig;
    len7    = {1'b0, blen} + {6'b0, slen_r};
    lead    = (!flags_r[FLAG_LEFT] && !zp_r) ? pad_r : 7'd0;
    b3      = lead + {6'b0, slen_r} + (zp_r ? pad_r : 7'd0);
  end

  // Character selection for the current output position.
  always_comb begin
    if (neg_r) begin
      sign_chr = CHR_MINUS;
    end else if (flags_r[FLAG_FORCE_PLUS]) begin
      sign_chr = CHR_PLUS;
    end else begin
      sign_chr = CHR_SPACE;
    end
    in_digits = (pos_r >= b4_r) && (pos_r < b5_r);
    emit_last = (pos_r + 7'd1 == total_r);
  end

  // Sequencer next-state logic.
  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    ndig_nxt      = ndig_r;
    width_nxt     = width_r;
    prec_nxt      = prec_r;
    flags_nxt     = flags_r;
    neg_nxt       = neg_r;
    pad_nxt       = pad_r;
    zeros_nxt     = zeros_r;
    slen_nxt      = slen_r;
    zp_nxt        = zp_r;
    b1_nxt        = b1_r;
    b2_nxt        = b2_r;
    b4_nxt        = b4_r;
    b5_nxt        = b5_r;
    total_nxt     = total_r;
    pos_nxt       = pos_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_last_nxt  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          neg_nxt  = in_value[VAL_W-1];
          mag_nxt  = in_value[VAL_W-1] ? (~in_value + 64'd1) : in_value;
          bcd_nxt  = '0;
          cnt_nxt  = '0;
          ndig_nxt = 5'(NUM_DIGITS);
          // The most negative value prints as plain signed text.
          if (most_neg) begin
            width_nxt = '0;
            prec_nxt  = '0;
            flags_nxt = '0;
          end else begin
            width_nxt = (in_field_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH)
                                                         : in_field_width;
            prec_nxt  = (in_min_digits > 6'(MAX_PRECISION)) ? 6'(MAX_PRECISION)
                                                            : in_min_digits;
            flags_nxt = in_style_flags;
          end
          state_nxt = ST_CONV;
        end
      end

      ST_CONV: begin
        bcd_nxt = dab_out[DAB_W-1:VAL_W];
        mag_nxt = dab_out[VAL_W-1:0];
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(CONV_STEPS - 1)) begin
          state_nxt = ST_TRIM;
        end
      end

      // Strip leading zero digits one per cycle; zero ends with no digits.
      ST_TRIM: begin
        if ((ndig_r != 5'd0) && (bcd_r[BCD_W-1 -: 4] == 4'd0)) begin
          bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
          ndig_nxt = ndig_r - 5'd1;
        end else begin
          slen_nxt  = neg_r || flags_r[FLAG_FORCE_PLUS] || flags_r[FLAG_SPACE];
          zp_nxt    = flags_r[FLAG_ZERO] && !flags_r[FLAG_PREC] &&
                      !flags_r[FLAG_LEFT];
          state_nxt = ST_SETUP;
        end
      end

      ST_SETUP: begin
        zeros_nxt = blen - {1'b0, ndig_r};
        pad_nxt   = (width_r > len7) ? (width_r - len7) : 7'd0;
        b1_nxt    = '0;
        state_nxt = ST_LAYOUT;
      end

      // Region boundaries: lead spaces, sign, zero pad, precision zeros,
      // digits, trailing spaces.
      ST_LAYOUT: begin
        b1_nxt    = lead;
        b2_nxt    = lead + {6'b0, slen_r};
        b4_nxt    = b3 + {1'b0, zeros_r};
        b5_nxt    = b3 + {1'b0, zeros_r} + {2'b0, ndig_r};
        total_nxt = b3 + {1'b0, zeros_r} + {2'b0, ndig_r} +
                    (flags_r[FLAG_LEFT] ? pad_r : 7'd0);
        pos_nxt   = '0;
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (pos_r == total_r) begin
          state_nxt = ST_IDLE;
        end else begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = emit_last;
          if (pos_r < b1_r) begin
            out_char_nxt = CHR_SPACE;
          end else if (pos_r < b2_r) begin
            out_char_nxt = sign_chr;
          end else if (pos_r < b4_r) begin
            out_char_nxt = CHR_ZERO;
          end else if (in_digits) begin
            out_char_nxt = CHR_ZERO | {4'd0, bcd_r[BCD_W-1 -: 4]};
          end else begin
            out_char_nxt = CHR_SPACE;
          end
          if (in_digits) begin
            bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
          end
          pos_nxt = pos_r + 7'd1;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers take reset; the data path does not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    ndig_r     <= ndig_nxt;
    width_r    <= width_nxt;
    prec_r     <= prec_nxt;
    flags_r    <= flags_nxt;
    neg_r      <= neg_nxt;
    pad_r      <= pad_nxt;
    zeros_r    <= zeros_nxt;
    slen_r     <= slen_nxt;
    zp_r       <= zp_nxt;
    b1_r       <= b1_nxt;
    b2_r       <= b2_nxt;
    b4_r       <= b4_nxt;
    b5_r       <= b5_nxt;
    total_r    <= total_nxt;
    pos_r      <= pos_nxt;
    out_char_r <= out_char_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  // An accepted value always keeps the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("accepted value did not make the block busy");

  // Characters of one text follow each other without gaps.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid)
    else $error("gap inside a character run");

  // The final character closes the run.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("transfer after the final character");

  // A character that is not the final one is only shown while busy.
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("character run outlived the busy window");

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for signed_decimal_text_formatter: a queued command
// driver, a result monitor and a printf-style decimal predictor.
// Depends on sdf_pkg and the formatter RTL.
`timescale 1ns / 100ps

module tb_top;
  import sdf_pkg::*;

  // Style flag masks built from the package bit positions.
  localparam logic [4:0] F_PLUS  = 5'(1 << FLAG_FORCE_PLUS);
  localparam logic [4:0] F_SPACE = 5'(1 << FLAG_SPACE);
  localparam logic [4:0] F_LEFT  = 5'(1 << FLAG_LEFT);
  localparam logic [4:0] F_ZERO  = 5'(1 << FLAG_ZERO);
  localparam logic [4:0] F_PREC  = 5'(1 << FLAG_PREC);

  localparam logic [63:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MOST_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam string MOST_NEG_TEXT = "-9223372036854775808";
  localparam int RANDOM_ITEMS = 300;
  localparam int DRAIN_CYCLES = 160;
  localparam int MAX_REPORTS = 10;

  // One formatting command, plus a request to let the block drain first.
  typedef struct {
    logic [63:0] value;
    logic [6:0]  width;
    logic [5:0]  prec;
    logic [4:0]  flags;
    bit          drain;
  } fmt_req_t;

  // One expected character transfer.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [63:0] in_value = '0;
  logic [6:0]  in_field_width = '0;
  logic [5:0]  in_min_digits = '0;
  logic [4:0]  in_style_flags = '0;
  logic        out_valid;
  logic [7:0]  out_character;
  logic        out_last;

  fmt_req_t   pending_reqs[$];
  text_char_t expected_text[$];
  int         error_count = 0;

  // Driver bookkeeping.
  bit take, go;
  int gap_left = 0;
  int burst_left = 0;

  signed_decimal_text_formatter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .in_field_width (in_field_width),
    .in_min_digits  (in_min_digits),
    .in_style_flags (in_style_flags),
    .out_valid      (out_valid),
    .out_character  (out_character),
    .out_last       (out_last)
  );

  // Free-running clock, 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Append the characters that one command should produce to the expected text.
  function automatic void format_signed_decimal(input logic [63:0] value,
                                                input logic [6:0] width_in,
                                                input logic [5:0] prec_in,
                                                input logic [4:0] flags);
    logic [7:0] text[$];
    logic [7:0] digits[$];
    logic [63:0] mag;
    logic [7:0] sign_ch;
    int width, prec, min_dig, blen, pad;
    bit neg, has_sign, zero_pad, left;
    if (value == MOST_NEGATIVE) begin
      // The most negative value has a fixed spelling regardless of the style.
      for (int i = 0; i < MOST_NEG_TEXT.len(); i++) begin
        text.push_back(MOST_NEG_TEXT[i]);
      end
    end else begin
      width = (int'(width_in) > MAX_WIDTH) ? MAX_WIDTH : int'(width_in);
      prec = (int'(prec_in) > MAX_PRECISION) ? MAX_PRECISION : int'(prec_in);
      neg = value[63];
      mag = neg ? (~value + 64'd1) : value;
      has_sign = 1'b1;
      sign_ch = CHR_MINUS;
      if (!neg) begin
        // Plus wins over space when both are requested.
        if (flags[FLAG_FORCE_PLUS]) sign_ch = CHR_PLUS;
        else if (flags[FLAG_SPACE]) sign_ch = CHR_SPACE;
        else has_sign = 1'b0;
      end
      left = flags[FLAG_LEFT];
      zero_pad = flags[FLAG_ZERO] && !flags[FLAG_PREC] && !left;
      min_dig = flags[FLAG_PREC] ? prec : 1;
      while (mag != 0) begin
        digits.push_front(CHR_ZERO + 8'(mag % 10));
        mag = mag / 10;
      end
      blen = (digits.size() > min_dig) ? digits.size() : min_dig;
      pad = width - (int'(has_sign) + blen);
      if (pad < 0) pad = 0;
      // Layout: right-justify spaces, sign, zero padding, precision zeros,
      // digits, then left-justify spaces.
      if (!left && !zero_pad) repeat (pad) text.push_back(CHR_SPACE);
      if (has_sign) text.push_back(sign_ch);
      if (zero_pad) repeat (pad) text.push_back(CHR_ZERO);
      repeat (blen - digits.size()) text.push_back(CHR_ZERO);
      foreach (digits[k]) text.push_back(digits[k]);
      if (left) repeat (pad) text.push_back(CHR_SPACE);
    end
    foreach (text[k]) begin
      expected_text.push_back('{ch: text[k], last: (k == text.size() - 1)});
    end
  endfunction

  task automatic add_req(input logic [63:0] value, input logic [6:0] width,
                         input logic [5:0] prec, input logic [4:0] flags,
                         input bit drain);
    pending_reqs.push_back('{value: value, width: width, prec: prec,
                             flags: flags, drain: drain});
  endtask

  // Driver: presents queued commands in bursts separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      take = start && !busy;
      if (take) begin
        format_signed_decimal(in_value, in_field_width, in_min_digits, in_style_flags);
        void'(pending_reqs.pop_front());
        if (burst_left > 0) burst_left--;
      end
      // A command still waiting for its transfer stays on the ports.
      if (!(start && !take)) begin
        go = 1'b0;
        if (burst_left == 0 && gap_left == 0) begin
          case ($urandom_range(0, 19))
            0, 1, 2:  gap_left = $urandom_range(20, 160);
            3, 4, 5, 6, 7, 8, 9: gap_left = $urandom_range(1, 8);
            default: gap_left = 0;
          endcase
          burst_left = $urandom_range(1, 20);
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_reqs.size() > 0 &&
                     !(pending_reqs[0].drain && expected_text.size() > 0)) begin
          go = 1'b1;
        end
        if (go) begin
          in_value       <= pending_reqs[0].value;
          in_field_width <= pending_reqs[0].width;
          in_min_digits  <= pending_reqs[0].prec;
          in_style_flags <= pending_reqs[0].flags;
        end
        start <= go;
      end
    end
  end

  // Monitor: every character transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_text.size() == 0) begin
        if (error_count < MAX_REPORTS) begin
          $display("ERROR: unexpected character 0x%02h last %0b", out_character, out_last);
        end
        error_count++;
      end else begin
        if (expected_text[0].ch !== out_character || expected_text[0].last !== out_last) begin
          if (error_count < MAX_REPORTS) begin
            $display("ERROR: expected character 0x%02h last %0b, got 0x%02h last %0b",
                     expected_text[0].ch, expected_text[0].last, out_character, out_last);
          end
          error_count++;
        end
        void'(expected_text.pop_front());
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    logic [63:0] v, p;
    logic [6:0]  w;
    logic [5:0]  pr;
    // Directed cases: extremes and each special rule of the format.
    add_req(MOST_NEGATIVE, 7'd127, 6'd63, 5'h1F, 1'b0);
    add_req(MOST_POSITIVE, 7'd0, 6'd0, 5'h00, 1'b0);
    add_req(64'd0, 7'd0, 6'd0, F_PREC, 1'b0);
    add_req(64'd0, 7'd0, 6'd0, F_PREC | F_PLUS, 1'b1);
    add_req(64'd0, 7'd5, 6'd0, F_PREC, 1'b0);
    add_req(64'd0, 7'd0, 6'd0, 5'h00, 1'b0);
    add_req(-64'sd1, 7'd10, 6'd0, F_ZERO, 1'b0);
    add_req(64'd42, 7'd0, 6'd0, F_PLUS | F_SPACE, 1'b0);
    add_req(64'd42, 7'd6, 6'd0, F_SPACE, 1'b0);
    add_req(64'd42, 7'd8, 6'd0, F_LEFT | F_ZERO, 1'b0);
    add_req(64'd123, 7'd10, 6'd6, F_PREC | F_ZERO, 1'b0);
    add_req(-64'sd5, 7'd64, 6'd0, F_LEFT | F_PLUS, 1'b0);
    add_req(64'd7, 7'd127, 6'd0, F_ZERO | F_SPACE, 1'b0);
    add_req(64'd7, 7'd0, 6'd63, F_PREC, 1'b0);
    add_req(-64'sd9, 7'd100, 6'd63, F_PREC | F_LEFT, 1'b0);
    add_req(64'd12345, 7'd3, 6'd0, 5'h00, 1'b0);
    add_req(64'd12345, 7'd0, 6'd3, F_PREC, 1'b0);
    add_req(64'd1, 7'd65, 6'd40, F_LEFT, 1'b0);
    add_req(MOST_NEGATIVE + 64'd1, 7'd0, 6'd0, F_SPACE, 1'b0);
    add_req(64'd1000000000000000000, 7'd30, 6'd0, F_PLUS | F_ZERO, 1'b0);
    add_req(-64'sd1000, 7'd12, 6'd0, F_SPACE | F_ZERO, 1'b0);
    add_req(MOST_POSITIVE, 7'd64, 6'd20, 5'h1F, 1'b1);

    // Random commands with mostly modest widths and a mix of value shapes.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: v = {$urandom, $urandom};
        3, 4:    v = 64'(longint'($urandom_range(0, 2000)) - 1000);
        5, 6: begin
          p = 64'd1;
          repeat ($urandom_range(0, 19)) p = p * 10;
          p = p + 64'($urandom_range(0, 2)) - 64'd1;
          v = $urandom_range(0, 1) ? -p : p;
        end
        7:       v = 64'd0;
        8: begin
          case ($urandom_range(0, 2))
            0:       v = MOST_NEGATIVE;
            1:       v = MOST_NEGATIVE + 64'd1;
            default: v = MOST_POSITIVE;
          endcase
        end
        default: v = 64'(longint'(int'($urandom)));
      endcase
      case ($urandom_range(0, 9))
        0:       w = 7'($urandom_range(0, 127));
        1, 2:    w = 7'($urandom_range(0, 64));
        default: w = 7'($urandom_range(0, 24));
      endcase
      pr = ($urandom_range(0, 4) < 3) ? 6'($urandom_range(0, 24)) : 6'($urandom_range(0, 63));
      add_req(v, w, pr, 5'($urandom_range(0, 31)), n == 0 || $urandom_range(0, 39) == 0);
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every command to be taken and every character to arrive.
    while (pending_reqs.size() > 0 || start || expected_text.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_text.size() > 0) begin
      $display("ERROR: %0d expected characters never arrived", expected_text.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: signed_decimal_text_formatter.f
sv/sdf_pkg.sv
sv/signed_decimal_text_formatter.sv
sim/tb_top.sv
